// ----- rtl/core/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder core.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int MAXCP_W = 21;
    localparam int ACC_W   = 26;
    localparam int LEFT_W  = 3;
    localparam int LOW_W   = 10;
    localparam int HI_W    = 11;
    localparam int WIDE_W  = ACC_W + 6;

    localparam logic [MAXCP_W-1:0] C_MAXCP_RESET = 21'h10FFFF;

    // Lead byte boundaries
    localparam logic [BYTE_W-1:0] C_ASCII_END = 8'h80;
    localparam logic [BYTE_W-1:0] C_LEAD3     = 8'hE0;
    localparam logic [BYTE_W-1:0] C_LEAD4     = 8'hF0;
    localparam logic [BYTE_W-1:0] C_LEAD5     = 8'hF8;
    localparam logic [BYTE_W-1:0] C_LEAD6     = 8'hFC;

    // Surrogate construction
    localparam logic [UNIT_W-1:0] C_HI_SURR    = 16'hD800;
    localparam logic [UNIT_W-1:0] C_LO_SURR    = 16'hDC00;
    localparam logic [HI_W-1:0]   C_SURR_OFS   = 11'h040;
    localparam logic [WIDE_W-1:0] C_BMP_MAX    = 32'h0000FFFF;

    // One decoded result beat
    typedef struct packed {
        logic              valid;
        logic [UNIT_W-1:0] code_unit;
        logic              is_error;
    } t_result;

endpackage

// ----- rtl/core/u8u16_in_reg.sv -----
// ----------------------------------------------------------------------------
// u8u16_in_reg
// Input register: captures one byte beat and holds it until the decoder
// takes it.
// ----------------------------------------------------------------------------
module u8u16_in_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [u8u16_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                          i_take,
    output logic                          o_full,
    output logic [u8u16_pkg::BYTE_W-1:0]  o_byte
);
    import u8u16_pkg::*;

    logic              r_full;
    logic              n_full;
    logic [BYTE_W-1:0] r_byte;

    // Accept whenever the slot is empty or drains this cycle
    assign o_ready = !r_full || i_take;
    assign n_full  = (i_valid && o_ready) || (r_full && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    // Load payload on an accepted beat
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_in_byte;
        end
    end

    assign o_full = r_full;
    assign o_byte = r_byte;

endmodule

// ----- rtl/core/u8u16_decode.sv -----
// ----------------------------------------------------------------------------
// u8u16_decode
// Decoder state and combinational next-state logic: one byte per advance,
// at most one UTF-16 unit or error result.
// ----------------------------------------------------------------------------
module u8u16_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [u8u16_pkg::BYTE_W-1:0]  i_byte,
    input  logic                          i_cfg_we,
    input  logic [u8u16_pkg::MAXCP_W-1:0] i_cfg_data,
    output u8u16_pkg::t_result            o_result
);
    import u8u16_pkg::*;

    logic [MAXCP_W-1:0] r_max_cp;
    logic [ACC_W-1:0]   r_acc,  n_acc;
    logic [LEFT_W-1:0]  r_left, n_left;
    logic               r_long, n_long;
    logic               r_lowp, n_lowp;
    logic [LOW_W-1:0]   r_low,  n_low;

    logic               cont;
    logic [5:0]         six;
    logic [ACC_W-1:0]   acc_sh;
    logic [LEFT_W-1:0]  left_dec;
    logic [WIDE_W-1:0]  wide;
    logic [HI_W-1:0]    hi;
    t_result            res;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cp <= C_MAXCP_RESET;
        end else if (i_cfg_we) begin
            r_max_cp <= i_cfg_data;
        end
    end

    assign cont     = (i_byte[7:6] == 2'b10);
    assign six      = i_byte[5:0];
    assign acc_sh   = {r_acc[ACC_W-7:0], six};
    assign left_dec = r_left - LEFT_W'(1);
    assign wide     = {acc_sh, 6'b0};
    assign hi       = wide[20:10] - C_SURR_OFS;

    // Next state and result for the byte in the input register
    always_comb begin
        n_acc  = r_acc;
        n_left = r_left;
        n_long = r_long;
        n_lowp = r_lowp;
        n_low  = r_low;
        res    = '0;
        if (r_left == '0) begin
            if (cont) begin
                res.valid    = 1'b1;
                res.is_error = 1'b1;
            end else if (i_byte < C_ASCII_END) begin
                res.valid = 1'b1;
                if (MAXCP_W'(i_byte) > r_max_cp) begin
                    res.is_error = 1'b1;
                end else begin
                    res.code_unit = UNIT_W'(i_byte);
                end
            end else begin
                // Open a sequence from the lead byte
                n_lowp = 1'b0;
                if (i_byte < C_LEAD3) begin
                    n_acc  = ACC_W'(i_byte[4:0]);
                    n_left = LEFT_W'(1);
                end else if (i_byte < C_LEAD4) begin
                    n_acc  = ACC_W'(i_byte[3:0]);
                    n_left = LEFT_W'(2);
                end else if (i_byte < C_LEAD5) begin
                    n_acc  = ACC_W'(i_byte[2:0]);
                    n_left = LEFT_W'(3);
                end else if (i_byte < C_LEAD6) begin
                    n_acc  = ACC_W'(i_byte[1:0]);
                    n_left = LEFT_W'(4);
                end else begin
                    n_acc  = ACC_W'(i_byte[1:0]);
                    n_left = LEFT_W'(5);
                end
                n_long = (i_byte >= C_LEAD4);
            end
        end else if (!cont) begin
            res.valid    = 1'b1;
            res.is_error = 1'b1;
        end else if (r_long && (r_left == LEFT_W'(1))) begin
            // Last byte of a long form
            res.valid = 1'b1;
            if (r_lowp) begin
                res.code_unit = C_LO_SURR | UNIT_W'(r_low) | UNIT_W'(six);
            end else begin
                res.code_unit = r_acc[UNIT_W-1:0] | UNIT_W'(six);
            end
            n_acc  = '0;
            n_left = '0;
            n_long = 1'b0;
            n_lowp = 1'b0;
            n_low  = '0;
        end else begin
            n_acc  = acc_sh;
            n_left = left_dec;
            if (!r_long) begin
                if (left_dec == '0) begin
                    res.valid = 1'b1;
                    if (acc_sh > ACC_W'(r_max_cp)) begin
                        res.is_error = 1'b1;
                    end else begin
                        res.code_unit = acc_sh[UNIT_W-1:0];
                    end
                    n_acc = '0;
                end
            end else if (left_dec == LEFT_W'(1)) begin
                // Test the long form one byte early
                if (wide > WIDE_W'(r_max_cp)) begin
                    res.valid    = 1'b1;
                    res.is_error = 1'b1;
                end else if (wide > C_BMP_MAX) begin
                    res.valid     = 1'b1;
                    res.code_unit = C_HI_SURR | UNIT_W'(hi);
                    n_low         = wide[LOW_W-1:0];
                    n_lowp        = 1'b1;
                    n_acc         = '0;
                end else begin
                    n_acc = wide[ACC_W-1:0];
                end
            end
        end
        // Any error drops the open sequence
        if (res.is_error) begin
            n_acc  = '0;
            n_left = '0;
            n_long = 1'b0;
            n_lowp = 1'b0;
            n_low  = '0;
        end
    end

    // Decoder state, updated on each advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_left <= '0;
            r_long <= 1'b0;
            r_lowp <= 1'b0;
            r_low  <= '0;
        end else if (i_adv) begin
            r_acc  <= n_acc;
            r_left <= n_left;
            r_long <= n_long;
            r_lowp <= n_lowp;
            r_low  <= n_low;
        end
    end

    assign o_result = res;

endmodule

// ----- rtl/core/u8u16_out_reg.sv -----
// ----------------------------------------------------------------------------
// u8u16_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module u8u16_out_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  u8u16_pkg::t_result            i_result,
    output logic                          o_free,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [u8u16_pkg::UNIT_W-1:0]  o_code_unit,
    output logic                          o_is_error
);
    import u8u16_pkg::*;

    logic              r_valid;
    logic [UNIT_W-1:0] r_unit;
    logic              r_err;

    // Slot can take a new beat when empty or draining
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_result.valid;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_result.valid) begin
            r_unit <= i_result.code_unit;
            r_err  <= i_result.is_error;
        end
    end

    assign o_valid     = r_valid;
    assign o_code_unit = r_unit;
    assign o_is_error  = r_err;

endmodule

// ----- rtl/core/utf8_to_utf16_decoder_core.sv -----
// Path: an accepted byte beat is held in the input register, decoded, then its result beat is registered.
// Throughput: one byte per cycle while the result slot is free; the decoder state loop updates once per advance.
// A byte that completes nothing still occupies the advance but emits no beat.
// Reset (i_rst_n low, synchronous): decoder idle, max code point 0x10FFFF.
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_core
// Top level: input register, decoder, and result register in one pass.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [u8u16_pkg::BYTE_W-1:0]  i_in_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [u8u16_pkg::UNIT_W-1:0]  o_code_unit,
    output logic                          o_is_error,
    input  logic                          i_cfg_we,
    input  logic [u8u16_pkg::MAXCP_W-1:0] i_cfg_data
);
    import u8u16_pkg::*;

    logic              in_full;
    logic [BYTE_W-1:0] in_byte;
    logic              out_free;
    logic              adv;
    t_result           result;

    // Advance when a byte waits and the result slot is free
    assign adv = in_full && out_free;

    u8u16_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .i_take    (adv),
        .o_full    (in_full),
        .o_byte    (in_byte)
    );

    u8u16_decode u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_byte     (in_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_result   (result)
    );

    u8u16_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (adv),
        .i_result    (result),
        .o_free      (out_free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_code_unit (o_code_unit),
        .o_is_error  (o_is_error)
    );

endmodule
